>>> design/pifm_pkg.sv
package pifm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TIME_WIDTH = 32;
    localparam longint unsigned TICKS_PER_SECOND = 64'd1000000;

    localparam int FREQ_WIDTH = 30;
    localparam longint unsigned MHZ_PER_HZ = 64'd1000;
    localparam longint unsigned FREQ_MAX_VAL = 64'd1000000000;
    localparam longint unsigned DIVIDEND_VAL = MHZ_PER_HZ * TICKS_PER_SECOND;

    localparam int DIVIDEND_WIDTH = $clog2(DIVIDEND_VAL + 64'd1);
    localparam int CNT_WIDTH = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;
    localparam int CMP_WIDTH = (DIVIDEND_WIDTH > FREQ_WIDTH) ? DIVIDEND_WIDTH : FREQ_WIDTH;

    localparam logic [DIVIDEND_WIDTH-1:0] DIVIDEND = DIVIDEND_WIDTH'(DIVIDEND_VAL);
    localparam logic [CMP_WIDTH-1:0] FREQ_MAX = CMP_WIDTH'(FREQ_MAX_VAL);
    localparam logic [CNT_WIDTH-1:0] DIV_STEPS_LAST = CNT_WIDTH'(DIVIDEND_WIDTH - 1);

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic load_result;
        logic load_error;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
        logic emits_error;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

>>> design/pifm_sample_if.sv
interface pifm_sample_if
    import pifm_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [TIME_WIDTH-1:0]          timestamp_us;

    modport source (output valid, output sample, output timestamp_us, input ready);
    modport sink (input valid, input sample, input timestamp_us, output ready);
endinterface

>>> design/pifm_result_if.sv
interface pifm_result_if
    import pifm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FREQ_WIDTH-1:0] frequency_mhz;
    logic                  status;

    modport source (output valid, output frequency_mhz, output status, input ready);
    modport sink (input valid, input frequency_mhz, input status, output ready);
endinterface

>>> design/peak_interval_frequency_meter.sv
// Peak interval frequency meter.
// sample_ch (sink) takes one signed sample and its microsecond timestamp per
// transaction; result_ch (source) gives frequency_mhz and status, at most one
// result per sample (only on the negative crossing that closes a measurement).
// A sample that yields no result, or a result with status 1, is handled
// without leaving the idle state. A valid measurement runs a restoring
// divider, one quotient bit per cycle, over DIVIDEND_WIDTH (30) quotient
// bits, and then loads the result register; no new sample is taken until
// the result is loaded.
// The result register holds one transaction. While it is full and result_ch
// is not ready, sample_ch ready stays low, and a finished division waits too.
// Reset (rst_n low, asynchronous) returns to the first phase with no peak,
// clears the crossing latch, both peak times and any pending result.
module peak_interval_frequency_meter
    import pifm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pifm_sample_if.sink   sample_ch,
    pifm_result_if.source result_ch
);

    cmd_t  cmd;
    stat_t stat;

    pifm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pifm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (sample_ch.sample),
        .timestamp_us  (sample_ch.timestamp_us),
        .out_valid     (result_ch.valid),
        .out_ready     (result_ch.ready),
        .frequency_mhz (result_ch.frequency_mhz),
        .status        (result_ch.status)
    );

endmodule

>>> design/pifm_ctrl.sv
module pifm_ctrl
    import pifm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.needs_div)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                cmd.div_start = accept && stat.needs_div;
                cmd.load_error = accept && stat.emits_error;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_result = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/pifm_dp.sv
module pifm_dp
    import pifm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    output stat_t                          stat,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [TIME_WIDTH-1:0]          timestamp_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [FREQ_WIDTH-1:0]          frequency_mhz,
    output logic                           status
);

    logic                           phase2_reg, phase2_next;
    logic                           latched_reg, latched_next;
    logic signed [SAMPLE_WIDTH-1:0] peak_reg, peak_next;
    logic [TIME_WIDTH-1:0]          t1_reg, t1_next;
    logic [TIME_WIDTH-1:0]          t2_reg, t2_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CNT_WIDTH-1:0]           cnt_reg, cnt_next;

    logic [TIME_WIDTH-1:0]          divisor_reg, divisor_next;
    logic [TIME_WIDTH-1:0]          rem_reg, rem_next;
    logic [DIVIDEND_WIDTH-1:0]      quo_reg, quo_next;
    logic [FREQ_WIDTH-1:0]          freq_reg, freq_next;
    logic                           status_reg, status_next;

    logic                  is_pos;
    logic                  is_neg;
    logic                  trigger;
    logic [TIME_WIDTH-1:0] period;
    logic                  meas_ok;
    logic [TIME_WIDTH:0]   trial;
    logic                  fits;
    logic [CMP_WIDTH-1:0]  quo_ext;
    logic [FREQ_WIDTH-1:0] quo_sat;

    assign is_neg = sample[SAMPLE_WIDTH-1];
    assign is_pos = !is_neg && (sample != '0);
    assign trigger = is_neg && !latched_reg && phase2_reg;
    assign period = t2_reg - t1_reg;
    assign meas_ok = (peak_reg != '0) && (period != '0);

    assign stat.needs_div = trigger && meas_ok;
    assign stat.emits_error = trigger && !meas_ok;
    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign fits = trial >= {1'b0, divisor_reg};

    assign quo_ext = CMP_WIDTH'(quo_reg);
    assign quo_sat = (quo_ext > FREQ_MAX) ? FREQ_WIDTH'(FREQ_MAX) : FREQ_WIDTH'(quo_ext);

    always_comb
    begin
        phase2_next = phase2_reg;
        latched_next = latched_reg;
        peak_next = peak_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        if (cmd.accept)
        begin
            if (is_pos)
            begin
                latched_next = 1'b0;
                if ((peak_reg == '0) || (sample > peak_reg))
                begin
                    peak_next = sample;
                    if (phase2_reg)
                    begin
                        t2_next = timestamp_us;
                    end
                    else
                    begin
                        t1_next = timestamp_us;
                    end
                end
            end
            else if (is_neg && !latched_reg)
            begin
                latched_next = 1'b1;
                peak_next = '0;
                phase2_next = !phase2_reg;
                if (phase2_reg)
                begin
                    t1_next = '0;
                    t2_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        divisor_next = divisor_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            divisor_next = period;
            rem_next = '0;
            quo_next = DIVIDEND;
            cnt_next = DIV_STEPS_LAST;
        end
        else if (cmd.div_step)
        begin
            rem_next = fits ? TIME_WIDTH'(trial - {1'b0, divisor_reg})
                            : TIME_WIDTH'(trial);
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            cnt_next = cnt_reg - CNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        freq_next = freq_reg;
        status_next = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_error)
        begin
            out_valid_next = 1'b1;
            freq_next = '0;
            status_next = STATUS_ERR;
        end
        else if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
            freq_next = quo_sat;
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase2_reg <= 1'b0;
            latched_reg <= 1'b0;
            peak_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            phase2_reg <= phase2_next;
            latched_reg <= latched_next;
            peak_reg <= peak_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        freq_reg <= freq_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign frequency_mhz = freq_reg;
    assign status = status_reg;

endmodule

>>> sim/peak_interval_frequency_meter_test.sv
`timescale 1ns / 100ps

module peak_interval_frequency_meter_test;
    import pifm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned MHZ_DIVIDEND = 64'd1000 * TICKS_PER_SECOND;
    localparam longint unsigned FREQ_LIMIT = 64'd1000000000;

    typedef struct packed {
        logic [FREQ_WIDTH-1:0] frequency_mhz;
        logic                  status;
    } meas_t;

    logic clk;
    logic rst_n;

    pifm_sample_if sample_bus ();
    pifm_result_if result_bus ();

    peak_interval_frequency_meter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus)
    );

    // predictor state
    logic                           second_phase;
    logic                           crossing_seen;
    logic signed [SAMPLE_WIDTH-1:0] peak_value;
    logic [TIME_WIDTH-1:0]          first_peak_us;
    logic [TIME_WIDTH-1:0]          second_peak_us;
    meas_t                          expected_meas[$];

    logic [TIME_WIDTH-1:0] now_us;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_req;
    int cycle_count = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int meas_checked = 0;
    int meas_flagged = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_count, expected_meas.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_bus.ready <= !hold_req && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_req <= 1'b0;
        forever
        begin
            wait (hold_req);
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_req <= 1'b0;
            wait (!hold_req);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        meas_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_meas.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction freq=%0d status=%0d",
                                          result_bus.frequency_mhz, result_bus.status));
            end
            else
            begin
                want = expected_meas.pop_front();
                meas_checked++;
                if (want.status == STATUS_ERR)
                    meas_flagged++;
                if (result_bus.frequency_mhz !== want.frequency_mhz)
                    report_mismatch($sformatf("frequency_mhz %0d, expected %0d",
                                              result_bus.frequency_mhz, want.frequency_mhz));
                if (result_bus.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_bus.status, want.status));
            end
        end
    end

    function automatic void predict_meter(input logic signed [SAMPLE_WIDTH-1:0] s,
                                          input logic [TIME_WIDTH-1:0] t);
        logic [TIME_WIDTH-1:0] period;
        longint unsigned quotient;
        meas_t m;
        if (s > 0)
        begin
            crossing_seen = 1'b0;
            if (peak_value == 0 || s > peak_value)
            begin
                peak_value = s;
                if (second_phase)
                    second_peak_us = t;
                else
                    first_peak_us = t;
            end
        end
        else if (s < 0 && !crossing_seen)
        begin
            crossing_seen = 1'b1;
            if (!second_phase)
            begin
                second_phase = 1'b1;
                peak_value = '0;
            end
            else
            begin
                period = second_peak_us - first_peak_us;
                m.frequency_mhz = '0;
                m.status = STATUS_ERR;
                if (peak_value != 0 && period != 0)
                begin
                    quotient = MHZ_DIVIDEND / period;
                    if (quotient > FREQ_LIMIT)
                        quotient = FREQ_LIMIT;
                    m.frequency_mhz = FREQ_WIDTH'(quotient);
                    m.status = STATUS_OK;
                end
                expected_meas.push_back(m);
                second_phase = 1'b0;
                first_peak_us = '0;
                second_peak_us = '0;
                peak_value = '0;
            end
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                               input logic [TIME_WIDTH-1:0] t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.sample <= s;
        sample_bus.timestamp_us <= t;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        predict_meter(s, t);
        samples_sent++;
    endtask

    task automatic release_sender();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [TIME_WIDTH-1:0] next_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            now_us = now_us;
        else if (r < 10)
            now_us = $urandom;
        else if (r < 20)
            now_us = now_us + $urandom_range(3, 1);
        else
            now_us = now_us + $urandom_range(5000, 1);
        return now_us;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_positive();
        if ($urandom_range(1))
            return SAMPLE_WIDTH'($urandom_range(32767, 1));
        return SAMPLE_WIDTH'($urandom_range(50, 1));
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_negative();
        logic [SAMPLE_WIDTH-1:0] mag;
        mag = SAMPLE_WIDTH'($urandom_range(32768, 1));
        return -mag;
    endfunction

    // one half swing: a run of positives then a run of negatives
    task automatic send_swing();
        int npos;
        int nneg;
        npos = $urandom_range(5, 1);
        nneg = $urandom_range(3, 1);
        repeat (npos) send_sample(rnd_positive(), next_stamp());
        repeat (nneg) send_sample(rnd_negative(), next_stamp());
    endtask

    task automatic test_directed();
        send_sample(16'sd0, 32'd77);
        send_sample(-16'sd32768, 32'd100);
        send_sample(-16'sd1, 32'd200);
        send_sample(16'sd32767, 32'd1000);
        send_sample(16'sd5, 32'd1100);
        send_sample(-16'sd5, 32'd1200);
        send_sample(-16'sd100, 32'd1300);
        // one tick period gives the largest frequency
        send_sample(16'sd1, 32'd2000);
        send_sample(16'sd2, 32'd2001);
        send_sample(-16'sd1, 32'd2001);
        send_sample(16'sd100, 32'd2002);
        send_sample(-16'sd1, 32'd2003);
        // zero period
        send_sample(16'sd7, 32'd5000);
        send_sample(-16'sd3, 32'd5001);
        send_sample(16'sd9, 32'd5000);
        send_sample(-16'sd3, 32'd5002);
        // wrapped time
        send_sample(16'sd10, 32'hFFFF_FFF0);
        send_sample(-16'sd1, 32'hFFFF_FFF8);
        send_sample(16'sd10, 32'h0000_0010);
        send_sample(-16'sd1, 32'h0000_0011);
        // longest period
        send_sample(16'sd20, 32'h0000_0000);
        send_sample(-16'sd1, 32'h0000_0001);
        send_sample(16'sd20, 32'hFFFF_FFFF);
        send_sample(-16'sd1, 32'h0000_0002);
        release_sender();
    endtask

    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = samples_sent + count;
        while (samples_sent < target)
        begin
            if ($urandom_range(99) < 80)
                send_swing();
            else
            begin
                case ($urandom_range(2))
                    0: send_sample('0, next_stamp());
                    1: send_sample(SAMPLE_WIDTH'($urandom), $urandom);
                    default: send_sample(SAMPLE_WIDTH'($urandom), next_stamp());
                endcase
            end
        end
        release_sender();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        repeat (6) send_swing();
        release_sender();
        wait (!hold_req);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        sample_bus.valid <= 1'b0;
        sample_bus.sample <= '0;
        sample_bus.timestamp_us <= '0;
        second_phase = 1'b0;
        crossing_seen = 1'b0;
        peak_value = '0;
        first_peak_us = '0;
        second_peak_us = '0;
        now_us = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 31;
        rx_idle_pct = 45;
        test_directed();
        test_random(240, 31, 45);
        test_backpressure();
        test_random(240, 45, 31);
        test_random(250, 0, 0);

        while (expected_meas.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples; checked %0d measurements (%0d flagged invalid)",
                 samples_sent, meas_checked, meas_flagged);
        $display("Covered peaks, crossings, wrap, saturation and a %0d cycle stall",
                 HOLD_CYCLES);
        if (mismatches == 0 && expected_meas.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/pifm_pkg.sv
design/pifm_sample_if.sv
design/pifm_result_if.sv
design/pifm_ctrl.sv
design/pifm_dp.sv
design/peak_interval_frequency_meter.sv
sim/peak_interval_frequency_meter_test.sv
